// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   localparam logic [1:0] CMD_PUT       = 2'd0;
   localparam logic [1:0] CMD_BACKSPACE = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;
   localparam logic [1:0] CMD_READ      = 2'd3;

   localparam logic [7:0]  CH_SPACE        = 8'd32;
   localparam logic [7:0]  CH_NEWLINE      = 8'd10;
   localparam logic [7:0]  RESET_ATTRIBUTE = 8'd15;
   localparam logic [15:0] RESET_BLANK     = {RESET_ATTRIBUTE, CH_SPACE};

   localparam int          CSR_AW        = 2;
   localparam logic [CSR_AW-1:0] REG_TEXT_ATTR = 2'd0;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  character;
      logic [10:0] cell_index;
   } req_item_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [7:0]  read_character;
      logic [7:0]  read_attribute;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL,
      ST_FINISH
   } seq_state_type;

endpackage

// ----- rtl/text_console_writer.sv -----
// Channel   Ports                        Beat carries
// request   req_valid/req_ready/req_item command, character, cell_index
// response  rsp_valid/rsp_ready/rsp_item cursor_position, read_character, read_attribute
// config    psel/penable/pwrite/paddr/.. text_attribute at byte address 0
//
// Put, newline, backspace and read do their cell RAM access when accepted,
// then hand the result to the output register from the finish state.
// Scroll and clear sweep the cell RAM, one cell per cycle on its single write
// port, with input stalled meanwhile.
// After reset a clearing pass fills the RAM with blanks; config writes are
// taken during it, requests are not.
// A stalled response holds in the output register; the next request is taken
// while it waits, and its result waits in the sequencer.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_item_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   // config register
   logic [7:0] attr_ff, attr_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         fin_valid;
   logic         fin_ready;
   rsp_item_type fin_item;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   assign pready = 1'b1;

   // single register; writes decode to any address in the port's range
   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && pready) begin
         attr_in = pwdata[7:0];
      end
   end

   assign prdata = (paddr == REG_TEXT_ATTR) ? {24'd0, attr_ff} : 32'd0;

   // output register takes a result when empty or being drained
   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_valid && fin_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= RESET_ATTRIBUTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         rsp_item_ff <= fin_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   tcw_sequencer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .AW      (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .text_attr (attr_ff),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_item  (fin_item),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   tcw_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ----- rtl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [15:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [15:0]   rdata
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tcw_sequencer.sv -----
module tcw_sequencer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int CELLS   = COLUMNS * ROWS,
   parameter int AW      = $clog2(CELLS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_item,
   input  logic [7:0]    text_attr,
   output logic          fin_valid,
   input  logic          fin_ready,
   output rsp_item_type  fin_item,
   output logic          ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [15:0]   ram_wdata,
   output logic          ram_re,
   output logic [AW-1:0] ram_raddr,
   input  logic [15:0]   ram_rdata
);

   localparam int            CW         = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [AW-1:0] BOTTOM_ROW = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
   localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

   seq_state_type state_ff, state_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] sw_ff, sw_in;
   logic          rd_hit_ff, rd_hit_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_copy_ff, pend_copy_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [15:0]   pend_fill_ff, pend_fill_in;

   logic          direct_we;
   logic [AW-1:0] direct_addr;
   logic [15:0]   direct_data;
   logic [15:0]   blank;
   logic [CW-1:0] col_next;
   logic          accept;
   logic          in_range;

   assign blank    = {text_attr, CH_SPACE};
   assign col_next = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
   assign in_range = (32'(req_item.cell_index) < 32'(CELLS));

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      sw_in         = sw_ff;
      rd_hit_in     = rd_hit_ff;
      pend_valid_in = 1'b0;
      pend_copy_in  = 1'b0;
      pend_addr_in  = sw_ff;
      pend_fill_in  = blank;
      direct_we     = 1'b0;
      direct_addr   = cursor_ff;
      direct_data   = blank;
      ram_re        = 1'b0;
      ram_raddr     = AW'(req_item.cell_index);
      fin_valid     = 1'b0;
      req_ready     = (state_ff == ST_IDLE) && !pend_valid_ff;
      accept        = req_valid && req_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_hit_in = 1'b0;
               state_in  = ST_FINISH;
               case (req_item.command)
                  CMD_PUT: begin
                     if (req_item.character == CH_NEWLINE) begin
                        if (cursor_ff >= BOTTOM_ROW) begin
                           state_in = ST_SCROLL;
                        end else begin
                           cursor_in = cursor_ff + ROW_STEP - AW'(col_ff);
                           col_in    = '0;
                        end
                     end else begin
                        direct_we   = 1'b1;
                        direct_data = {text_attr, req_item.character};
                        if (cursor_ff == LAST_CELL) begin
                           state_in = ST_SCROLL;
                        end else begin
                           cursor_in = cursor_ff + 1'b1;
                           col_in    = col_next;
                        end
                     end
                     if (state_in == ST_SCROLL) begin
                        cursor_in = BOTTOM_ROW;
                        col_in    = '0;
                        sw_in     = '0;
                     end
                  end
                  CMD_BACKSPACE: begin
                     if (cursor_ff != '0) begin
                        cursor_in   = cursor_ff - 1'b1;
                        col_in      = (col_ff == '0) ? LAST_COL : col_ff - 1'b1;
                        direct_we   = 1'b1;
                        direct_addr = cursor_ff - 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     cursor_in = '0;
                     col_in    = '0;
                     sw_in     = '0;
                     state_in  = ST_CLEAR;
                  end
                  CMD_READ: begin
                     ram_re    = in_range;
                     rd_hit_in = in_range;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_INIT, ST_CLEAR, ST_SCROLL: begin
            // one cell per cycle; the write lands in the next cycle together with the read data
            pend_valid_in = 1'b1;
            pend_copy_in  = (state_ff == ST_SCROLL) && (sw_ff < BOTTOM_ROW);
            pend_fill_in  = (state_ff == ST_INIT) ? RESET_BLANK : blank;
            if (pend_copy_in) begin
               ram_re    = 1'b1;
               ram_raddr = sw_ff + ROW_STEP;
            end
            if (sw_ff == LAST_CELL) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FINISH;
            end else begin
               sw_in = sw_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            fin_valid = 1'b1;
            if (fin_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_we    = pend_valid_ff || direct_we;
   assign ram_waddr = pend_valid_ff ? pend_addr_ff : direct_addr;
   assign ram_wdata = pend_valid_ff ? (pend_copy_ff ? ram_rdata : pend_fill_ff) : direct_data;

   assign fin_item.cursor_position = 11'(cursor_ff);
   assign fin_item.read_character  = rd_hit_ff ? ram_rdata[7:0]  : 8'd0;
   assign fin_item.read_attribute  = rd_hit_ff ? ram_rdata[15:8] : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cursor_ff     <= '0;
         col_ff        <= '0;
         sw_ff         <= '0;
         rd_hit_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         sw_ff         <= sw_in;
         rd_hit_ff     <= rd_hit_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_copy_ff <= pend_copy_in;
      pend_addr_ff <= pend_addr_in;
      pend_fill_ff <= pend_fill_in;
   end

   // sweep write and command write never share the single write port
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(pend_valid_ff && direct_we))
      else $error("sweep write collides with command write");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff <= LAST_CELL) && (col_ff <= LAST_COL))
      else $error("cursor or column out of range");

   a_col_tracks: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0) || (cursor_ff != '0))
      else $error("column counter out of step with cursor");

   a_finish_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && fin_ready) |=> (state_ff == ST_IDLE))
      else $error("result handed over but sequencer did not return to idle");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (cursor_ff == BOTTOM_ROW))
      else $error("cursor not on bottom row during scroll");

endmodule

// ----- bench/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   // A scroll or clear sweeps every cell; the post-reset clearing pass is about as long.
   localparam int SWEEP_WAIT  = CELLS + 4;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 50;
   localparam int PHASE_BEATS = 435;

   // Shadow of the screen: tracks cells, cursor and attribute, and queues the
   // response beat that each accepted command must produce.
   class console_shadow;
      logic [15:0]  cells [CELLS];
      logic [10:0]  cursor;
      logic [7:0]   attribute;
      rsp_item_type due_results [$];
      int           errors;

      function new();
         attribute = RESET_ATTRIBUTE;
         cursor    = '0;
         errors    = 0;
         blank_all(RESET_BLANK);
      endfunction

      function void blank_all(logic [15:0] blank);
         for (int i = 0; i < CELLS; i++) cells[i] = blank;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void fault(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void take_command(req_item_type it);
         rsp_item_type r;
         logic [15:0]  blank;
         int           pos;
         r     = '0;
         blank = {attribute, CH_SPACE};
         case (it.command)
            CMD_PUT: begin
               pos = int'(cursor);
               if (it.character == CH_NEWLINE) begin
                  pos = pos + COLUMNS - pos % COLUMNS;
               end else begin
                  cells[pos] = {attribute, it.character};
                  pos++;
               end
               // running off the end: scroll up one row, blank the bottom row
               if (pos >= CELLS) begin
                  for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = blank;
                  cursor = 11'(CELLS - COLUMNS);
               end else begin
                  cursor = 11'(pos);
               end
            end
            CMD_BACKSPACE: begin
               if (cursor != 0) begin
                  cursor--;
                  cells[cursor] = blank;
               end
            end
            CMD_CLEAR: begin
               blank_all(blank);
               cursor = '0;
            end
            CMD_READ: begin
               // off-screen addresses read back as zero
               if (it.cell_index < CELLS)
                  {r.read_attribute, r.read_character} = cells[it.cell_index];
            end
         endcase
         r.cursor_position = cursor;
         due_results.push_back(r);
      endfunction

      function void compare_result(rsp_item_type got);
         rsp_item_type want;
         if (due_results.size() == 0) begin
            fault($sformatf("unexpected response beat: cursor %0d char %02h attr %02h",
                            got.cursor_position, got.read_character, got.read_attribute));
            return;
         end
         want = due_results.pop_front();
         if (got.cursor_position !== want.cursor_position ||
             got.read_character  !== want.read_character  ||
             got.read_attribute  !== want.read_attribute)
            fault($sformatf({"response mismatch: expected cursor %0d char %02h attr %02h,",
                             " got cursor %0d char %02h attr %02h"},
                            want.cursor_position, want.read_character, want.read_attribute,
                            got.cursor_position, got.read_character, got.read_attribute));
      endfunction
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_item_type      req_item  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   rsp_item_type      rsp_item;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = REG_TEXT_ATTR;
   logic [31:0]       pwdata    = '0;
   logic [31:0]       prdata;
   logic              pready;

   console_shadow sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int requests_sent  = 0;
   int quiet_cycles   = 0;

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random back-pressure, plus a long hold whenever the
   // stimulus asks for one so the block backs up and stalls its input.
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response beats are checked at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.compare_result(rsp_item);
   end

   // Watchdog: too long without a beat on either channel means a hang.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_item_type make_item(logic [1:0] cmd, logic [7:0] ch,
                                              logic [10:0] idx);
      req_item_type it;
      it.command    = cmd;
      it.character  = ch;
      it.cell_index = idx;
      return it;
   endfunction

   // Reads mostly land where something interesting is: near the cursor and
   // in the bottom rows, which see every scroll.
   function automatic logic [10:0] pick_read_index();
      int off;
      off = $urandom_range(COLUMNS);
      case ($urandom_range(9))
         0, 1, 2: return 11'($urandom);
         3, 4, 5: return (sb.cursor > off) ? 11'(sb.cursor - off) : 11'd0;
         6, 7, 8: return 11'(CELLS - 1 - $urandom_range(2 * COLUMNS - 1));
         default: return 11'(CELLS + $urandom_range(2047 - CELLS));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is only dropped when a gap is actually taken.
   task automatic send_item(input req_item_type it);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      sb.take_command(it);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // APB write of the attribute register, then a read-back.
   task automatic write_attribute(input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_TEXT_ATTR;
      pwdata  <= {24'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.attribute = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== value)
         sb.fault($sformatf("attribute read-back: expected %02h, got %02h", value, prdata[7:0]));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random traffic built mostly from lines of text ending in newlines, so the
   // cursor walks down, wraps and scrolls; reads, backspaces, clears and raw
   // noise beats are mixed in.
   task automatic run_phase(input int beats, input bit long_hold, input bit mid_pause);
      int goal;
      int n;
      int r;
      bit hold_due;
      bit pause_due;
      goal      = requests_sent + beats;
      hold_due  = long_hold;
      pause_due = mid_pause;
      while (requests_sent < goal) begin
         if ((hold_due || pause_due) && requests_sent >= goal - beats / 2) begin
            if (hold_due) hold_requests++;
            if (pause_due) wait_for_drain();
            hold_due  = 1'b0;
            pause_due = 1'b0;
         end
         r = $urandom_range(99);
         if (r < 38) begin
            // mostly short lines; now and then one long enough to wrap or
            // run off the last cell
            n = $urandom_range(19);
            n = (n < 16) ? $urandom_range(24) :
                (n < 19) ? $urandom_range(100, 60) : $urandom_range(170, 100);
            repeat (n) send_item(make_item(CMD_PUT, 8'($urandom), 11'($urandom)));
            if ($urandom_range(9) < 7)
               send_item(make_item(CMD_PUT, CH_NEWLINE, 11'($urandom)));
         end else if (r < 48) begin
            repeat ($urandom_range(26, 1))
               send_item(make_item(CMD_PUT, CH_NEWLINE, 11'($urandom)));
         end else if (r < 73) begin
            repeat ($urandom_range(8, 1))
               send_item(make_item(CMD_READ, 8'($urandom), pick_read_index()));
         end else if (r < 83) begin
            repeat ($urandom_range(6, 1))
               send_item(make_item(CMD_BACKSPACE, 8'($urandom), 11'($urandom)));
         end else if (r < 85) begin
            send_item(make_item(CMD_CLEAR, 8'($urandom), 11'($urandom)));
         end else begin
            send_item(make_item(2'($urandom), 8'($urandom), 11'($urandom)));
         end
      end
   endtask

   initial begin
      logic [7:0] phase_attr [4];
      int         idle_pct   [4];
      int         stall_pct  [4];
      phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
      idle_pct   = '{0, 69, 0, 37};
      stall_pct  = '{0, 0, 69, 37};

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed beats at the reset attribute. The first waits out the
      // clearing pass, then reads a blank cell.
      send_item(make_item(CMD_READ, 8'hA5, 11'd0));
      send_item(make_item(CMD_READ, 8'h5A, 11'(CELLS - 1)));
      send_item(make_item(CMD_READ, 8'h00, 11'(CELLS)));          // just off screen
      send_item(make_item(CMD_READ, 8'hFF, 11'h7FF));             // far off screen
      send_item(make_item(CMD_BACKSPACE, 8'hFF, 11'h7FF));        // cursor at zero
      send_item(make_item(CMD_PUT, 8'h00, 11'h7FF));
      send_item(make_item(CMD_PUT, 8'hFF, 11'h000));
      send_item(make_item(CMD_PUT, CH_NEWLINE, 11'h555));
      send_item(make_item(CMD_READ, 8'h00, 11'd0));
      send_item(make_item(CMD_READ, 8'hFF, 11'd1));
      send_item(make_item(CMD_BACKSPACE, 8'h00, 11'h2AA));        // back across a row end
      send_item(make_item(CMD_BACKSPACE, 8'h00, 11'h000));
      send_item(make_item(CMD_READ, 8'h00, 11'(COLUMNS - 1)));
      send_item(make_item(CMD_PUT, 8'h41, 11'h000));
      send_item(make_item(CMD_CLEAR, 8'hFF, 11'h7FF));
      send_item(make_item(CMD_READ, 8'h00, 11'd0));

      for (int p = 0; p < 4; p++) begin
         // attribute changes only once the block has gone quiet, sweep included
         wait_for_drain();
         repeat (SWEEP_WAIT) @(negedge clock);
         write_attribute(phase_attr[p]);
         send_idle_pct  = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         // long response hold with the sender flat out, and a full drain
         // pause with the response side gappy
         run_phase(PHASE_BEATS, p == 0, p == 2);
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
